[rtl/utc_pkg.sv]
// Shared types and constants for the UTF-8 text console cursor block.
// Used by the front decoder, the command queue, the back cursor engine and the top level.
// No dependencies.
`default_nettype none

package utc_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CP_W      = 21;
  localparam int unsigned PORT_COL_W = 9;
  localparam int unsigned PORT_ROW_W = 8;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned CFG_COL_W = 10;
  localparam int unsigned CFG_ROW_W = 9;
  localparam int unsigned CFG_DAT_W = 10;

  // Register indexes of the configuration port
  localparam logic CFG_IDX_COLS = 1'b0;
  localparam logic CFG_IDX_ROWS = 1'b1;

  // Register reset values
  localparam logic [CFG_COL_W-1:0] COLS_RESET = 10'd80;
  localparam logic [CFG_ROW_W-1:0] ROWS_RESET = 9'd25;

  // Result action codes
  localparam logic [ACT_W-1:0] ACT_STATUS = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DRAW   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SCROLL = 2'd2;

  // Control code points
  localparam logic [CP_W-1:0] CP_NEWLINE = 21'h0000A;
  localparam logic [CP_W-1:0] CP_RETURN  = 21'h0000D;
  localparam logic [CP_W-1:0] CP_TAB     = 21'h00009;
  localparam logic [CP_W-1:0] CP_BACK    = 21'h00008;
  localparam logic [CP_W-1:0] CP_INVALID = 21'h0003F;

  // UTF-8 byte masks and patterns
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_PAT   = 8'h80;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_BITS = 8'h07;

  // Tab stops every four columns
  localparam int unsigned TAB_STEP = 4;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // What the back has to do with one input
  typedef enum logic [2:0] {
    CMD_STATUS,
    CMD_SETPOS,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_TAB,
    CMD_BACK,
    CMD_DRAW
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [CP_W-1:0]       cp;
    logic [PORT_COL_W-1:0] col;
    logic [PORT_ROW_W-1:0] row;
  } cmd_t;

  // Map a finished code point to the command it causes
  function automatic cmd_kind_e cp_kind(input logic [CP_W-1:0] cp);
    cmd_kind_e k;
    k = CMD_DRAW;
    if (cp == CP_NEWLINE) k = CMD_NEWLINE;
    else if (cp == CP_RETURN) k = CMD_RETURN;
    else if (cp == CP_TAB) k = CMD_TAB;
    else if (cp == CP_BACK) k = CMD_BACK;
    return k;
  endfunction

endpackage

`default_nettype wire

[rtl/utc_front.sv]
// Front part: accepts input transactions, runs the UTF-8 decoder and classifies
// each input into a cursor command. Depends on utc_pkg.
`default_nettype none

module utc_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            req_type_i,
  input  wire  [7:0]                     byte_in_i,
  input  wire  [utc_pkg::PORT_COL_W-1:0] new_col_i,
  input  wire  [utc_pkg::PORT_ROW_W-1:0] new_row_i,
  output logic                           cmd_valid_o,
  input  wire                            cmd_ready_i,
  output utc_pkg::cmd_t                  cmd_o
);
  import utc_pkg::*;

  logic [1:0]      owed_q, owed_d;
  logic [CP_W-1:0] partial_q, partial_d;
  logic [CP_W-1:0] merged;
  logic [CP_W-1:0] byte_cp;
  logic            accept;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i & cmd_ready_i;

  assign byte_cp = CP_W'(byte_in_i);
  assign merged  = {partial_q[CP_W-7:0], byte_in_i[5:0]};

  // Decoder step and classification
  always_comb begin
    owed_d     = owed_q;
    partial_d  = partial_q;
    cmd_o.kind = CMD_STATUS;
    cmd_o.cp   = '0;
    cmd_o.col  = new_col_i;
    cmd_o.row  = new_row_i;
    if (req_type_i) begin
      cmd_o.kind = CMD_SETPOS;
    end else if (!byte_in_i[7]) begin
      owed_d     = 2'd0;
      partial_d  = '0;
      cmd_o.kind = cp_kind(byte_cp);
      cmd_o.cp   = byte_cp;
    end else if ((byte_in_i & LEAD2_MASK) == LEAD2_PAT) begin
      owed_d    = 2'd1;
      partial_d = CP_W'(byte_in_i & LEAD2_BITS);
    end else if ((byte_in_i & LEAD3_MASK) == LEAD3_PAT) begin
      owed_d    = 2'd2;
      partial_d = CP_W'(byte_in_i & LEAD3_BITS);
    end else if ((byte_in_i & LEAD4_MASK) == LEAD4_PAT) begin
      owed_d    = 2'd3;
      partial_d = CP_W'(byte_in_i & LEAD4_BITS);
    end else if (((byte_in_i & CONT_MASK) == CONT_PAT) && (owed_q != 2'd0)) begin
      owed_d = owed_q - 2'd1;
      if (owed_q == 2'd1) begin
        // sequence complete
        partial_d  = '0;
        cmd_o.kind = cp_kind(merged);
        cmd_o.cp   = merged;
      end else begin
        partial_d = merged;
      end
    end else begin
      // stray continuation or invalid byte
      owed_d     = 2'd0;
      partial_d  = '0;
      cmd_o.kind = CMD_DRAW;
      cmd_o.cp   = CP_INVALID;
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q    <= 2'd0;
      partial_q <= '0;
    end else if (accept) begin
      owed_q    <= owed_d;
      partial_q <= partial_d;
    end
  end

endmodule

`default_nettype wire

[rtl/utc_queue.sv]
// Short command queue between the front decoder and the back cursor engine.
// Depends on utc_pkg for the command type and depth.
`default_nettype none

module utc_queue (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_valid_i,
  output logic          push_ready_o,
  input  utc_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  wire           pop_ready_i,
  output utc_pkg::cmd_t pop_data_o
);
  import utc_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

[rtl/utc_back.sv]
// Back part: holds the text cursor, carries out queued commands and drives the
// registered result channel (draw, scroll, status). Depends on utc_pkg.
`default_nettype none

module utc_back #(
  parameter int unsigned MAX_COLS = 512,
  parameter int unsigned MAX_ROWS = 256
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire  [utc_pkg::CFG_COL_W-1:0]  cols_cfg_i,
  input  wire  [utc_pkg::CFG_ROW_W-1:0]  rows_cfg_i,
  input  wire                            cmd_valid_i,
  output logic                           cmd_ready_o,
  input  utc_pkg::cmd_t                  cmd_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [utc_pkg::ACT_W-1:0]      action_o,
  output logic [utc_pkg::CP_W-1:0]       code_point_o,
  output logic [utc_pkg::PORT_COL_W-1:0] at_col_o,
  output logic [utc_pkg::PORT_ROW_W-1:0] at_row_o,
  output logic [utc_pkg::PORT_COL_W-1:0] pos_col_o,
  output logic [utc_pkg::PORT_ROW_W-1:0] pos_row_o,
  output logic                           last_o
);
  import utc_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned ECW = $clog2(MAX_COLS + 1);
  localparam int unsigned ERW = $clog2(MAX_ROWS + 1);

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [ECW-1:0] cols_eff;
  logic [ERW-1:0] rows_eff;
  logic [31:0]    cols_w, rows_w;
  logic [31:0]    row_inc_w, col_inc_w, tab_w;
  logic           nl_scroll;
  logic [RW-1:0]  nl_row;
  logic           scroll, draw;
  logic           out_valid_q, pend_q;
  logic           out_free, pop;

  // Effective screen size: zero acts as one, clamp at the maximum
  always_comb begin
    cols_w = 32'(cols_cfg_i);
    rows_w = 32'(rows_cfg_i);
    if (cols_w == 32'd0) cols_w = 32'd1;
    if (cols_w > MAX_COLS) cols_w = MAX_COLS;
    if (rows_w == 32'd0) rows_w = 32'd1;
    if (rows_w > MAX_ROWS) rows_w = MAX_ROWS;
    cols_eff = ECW'(cols_w);
    rows_eff = ERW'(rows_w);
  end

  // Next-line step, with scroll when it passes the last row
  assign row_inc_w = 32'(row_q) + 32'd1;
  assign nl_scroll = (row_inc_w >= 32'(rows_eff));
  assign nl_row    = nl_scroll ? RW'(rows_eff - 1'b1) : RW'(row_inc_w);
  assign col_inc_w = 32'(col_q) + 32'd1;
  assign tab_w     = (32'(col_q) + TAB_STEP) & ~(TAB_STEP - 1);

  // Command execution
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    scroll = 1'b0;
    draw   = 1'b0;
    case (cmd_i.kind)
      CMD_STATUS: ;
      CMD_SETPOS: begin
        if (32'(cmd_i.col) < 32'(cols_eff)) col_d = CW'(cmd_i.col);
        if (32'(cmd_i.row) < 32'(rows_eff)) row_d = RW'(cmd_i.row);
      end
      CMD_NEWLINE: begin
        col_d  = '0;
        row_d  = nl_row;
        scroll = nl_scroll;
      end
      CMD_RETURN: col_d = '0;
      CMD_TAB: begin
        if (tab_w >= 32'(cols_eff)) begin
          col_d  = '0;
          row_d  = nl_row;
          scroll = nl_scroll;
        end else begin
          col_d = CW'(tab_w);
        end
      end
      CMD_BACK: begin
        if (col_q != '0) col_d = col_q - 1'b1;
      end
      CMD_DRAW: begin
        draw = 1'b1;
        if (col_inc_w >= 32'(cols_eff)) begin
          col_d  = '0;
          row_d  = nl_row;
          scroll = nl_scroll;
        end else begin
          col_d = CW'(col_inc_w);
        end
      end
      default: ;
    endcase
  end

  // Output slot handshake; a pending scroll blocks the next command
  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = out_free && !pend_q;
  assign pop         = cmd_ready_o && cmd_valid_i;
  assign out_valid_o = out_valid_q;

  // Control state: cursor, output valid, pending second result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (out_free) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else if (cmd_valid_i) begin
        out_valid_q <= 1'b1;
        pend_q      <= draw && scroll;
        col_q       <= col_d;
        row_q       <= row_d;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (out_free && pend_q) begin
      action_o     <= ACT_SCROLL;
      code_point_o <= '0;
      at_col_o     <= '0;
      at_row_o     <= '0;
      pos_col_o    <= PORT_COL_W'(col_q);
      pos_row_o    <= PORT_ROW_W'(row_q);
      last_o       <= 1'b1;
    end else if (pop) begin
      pos_col_o <= PORT_COL_W'(col_d);
      pos_row_o <= PORT_ROW_W'(row_d);
      if (draw) begin
        action_o     <= ACT_DRAW;
        code_point_o <= cmd_i.cp;
        at_col_o     <= PORT_COL_W'(col_q);
        at_row_o     <= PORT_ROW_W'(row_q);
        last_o       <= !scroll;
      end else begin
        action_o     <= scroll ? ACT_SCROLL : ACT_STATUS;
        code_point_o <= '0;
        at_col_o     <= '0;
        at_row_o     <= '0;
        last_o       <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/utf8_text_console_cursor.sv]
// UTF-8 text console cursor engine, top level. Each input transaction is a console
// byte or a set-cursor request; it gives one result (status, or a draw or scroll
// command) or two (a draw followed by a scroll), the last one flagged by last_o,
// each carrying the cursor after the whole input. The front decoder takes one input
// per cycle into a two-entry command queue while it has room; the back cursor engine
// retires one command per cycle into a registered result slot while free and no scroll
// is pending, so the block sustains one input per clock while each input yields one
// result, and a draw that scrolls holds the back for its second result, as the result
// channel carries one result per clock. Inputs pass the queue and the result register.
// Column and row counts must be written through the configuration port only while
// idle; this is not enforced. Depends on utc_pkg, utc_front, utc_queue and utc_back.
`default_nettype none

module utf8_text_console_cursor #(
  parameter int unsigned MAX_COLS = 512,
  parameter int unsigned MAX_ROWS = 256
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire                            cfg_index_i,
  input  wire  [utc_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            req_type_i,
  input  wire  [7:0]                     byte_in_i,
  input  wire  [utc_pkg::PORT_COL_W-1:0] new_col_i,
  input  wire  [utc_pkg::PORT_ROW_W-1:0] new_row_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [utc_pkg::ACT_W-1:0]      action_o,
  output logic [utc_pkg::CP_W-1:0]       code_point_o,
  output logic [utc_pkg::PORT_COL_W-1:0] at_col_o,
  output logic [utc_pkg::PORT_ROW_W-1:0] at_row_o,
  output logic [utc_pkg::PORT_COL_W-1:0] pos_col_o,
  output logic [utc_pkg::PORT_ROW_W-1:0] pos_row_o,
  output logic                           last_o
);
  import utc_pkg::*;

  logic [CFG_COL_W-1:0] cols_q;
  logic [CFG_ROW_W-1:0] rows_q;
  logic                 fr_valid, fr_ready;
  cmd_t                 fr_cmd;
  logic                 bk_valid, bk_ready;
  cmd_t                 bk_cmd;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_COLS: cols_q <= cfg_data_i[CFG_COL_W-1:0];
        CFG_IDX_ROWS: rows_q <= cfg_data_i[CFG_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Decoder front
  utc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .byte_in_i   (byte_in_i),
    .new_col_i   (new_col_i),
    .new_row_i   (new_row_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  // Command queue
  utc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_cmd)
  );

  // Cursor engine back
  utc_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cols_cfg_i   (cols_q),
    .rows_cfg_i   (rows_q),
    .cmd_valid_i  (bk_valid),
    .cmd_ready_o  (bk_ready),
    .cmd_i        (bk_cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .action_o     (action_o),
    .code_point_o (code_point_o),
    .at_col_o     (at_col_o),
    .at_row_o     (at_row_o),
    .pos_col_o    (pos_col_o),
    .pos_row_o    (pos_row_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for utf8_text_console_cursor: UTF-8 decode, cursor moves,
// wrap and scroll, set-cursor requests and column/row register writes, under stalls.
// Depends on utc_pkg and the utf8_text_console_cursor RTL.
`timescale 1ns / 1ps

module tb_top;
  import utc_pkg::*;

  localparam int unsigned SCREEN_MAX_COLS = 512;
  localparam int unsigned SCREEN_MAX_ROWS = 256;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_CYCLES     = 300;

  typedef enum logic {
    REQ_BYTE   = 1'b0,
    REQ_SETPOS = 1'b1
  } req_kind_e;

  typedef struct packed {
    req_kind_e              kind;
    logic [7:0]             data;
    logic [PORT_COL_W-1:0]  col;
    logic [PORT_ROW_W-1:0]  row;
  } console_req_t;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [CP_W-1:0]       cp;
    logic [PORT_COL_W-1:0] at_col;
    logic [PORT_ROW_W-1:0] at_row;
    logic [PORT_COL_W-1:0] pos_col;
    logic [PORT_ROW_W-1:0] pos_row;
    logic                  last;
  } screen_op_t;

  // Clock, reset and block inputs, all known from time zero
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_index_i = CFG_IDX_COLS;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic req_type_i = 1'b0;
  logic [7:0] byte_in_i = '0;
  logic [PORT_COL_W-1:0] new_col_i = '0;
  logic [PORT_ROW_W-1:0] new_row_i = '0;
  logic out_ready_i = 1'b0;

  logic cfg_ready_o, in_ready_o, out_valid_o, last_o;
  logic [ACT_W-1:0] action_o;
  logic [CP_W-1:0] code_point_o;
  logic [PORT_COL_W-1:0] at_col_o, pos_col_o;
  logic [PORT_ROW_W-1:0] at_row_o, pos_row_o;

  // Cursor and decoder state as the block should hold it
  logic [CFG_COL_W-1:0] cols_reg = COLS_RESET;
  logic [CFG_ROW_W-1:0] rows_reg = ROWS_RESET;
  int unsigned caret_c = 0;
  int unsigned caret_r = 0;
  int unsigned owed = 0;
  logic [CP_W-1:0] partial = '0;

  screen_op_t screen_ops_due[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_len = 0;
  bit idle_on = 1'b0;
  bit stall_on = 1'b0;

  utf8_text_console_cursor #(
    .MAX_COLS(SCREEN_MAX_COLS),
    .MAX_ROWS(SCREEN_MAX_ROWS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .req_type_i(req_type_i),
    .byte_in_i(byte_in_i),
    .new_col_i(new_col_i),
    .new_row_i(new_row_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .action_o(action_o),
    .code_point_o(code_point_o),
    .at_col_o(at_col_o),
    .at_row_o(at_row_o),
    .pos_col_o(pos_col_o),
    .pos_row_o(pos_row_o),
    .last_o(last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Effective screen size: zero acts as one, oversize clamps to the maximum
  function automatic int unsigned screen_cols();
    int unsigned c;
    c = 32'(cols_reg);
    if (c == 0) c = 1;
    else if (c > SCREEN_MAX_COLS) c = SCREEN_MAX_COLS;
    return c;
  endfunction

  function automatic int unsigned screen_rows();
    int unsigned r;
    r = 32'(rows_reg);
    if (r == 0) r = 1;
    else if (r > SCREEN_MAX_ROWS) r = SCREEN_MAX_ROWS;
    return r;
  endfunction

  // Go to column 0 of the next row; returns 1 when the screen has to scroll
  function automatic bit wrap_line();
    caret_c = 0;
    caret_r++;
    if (caret_r >= screen_rows()) begin
      caret_r = screen_rows() - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Decode one transaction, move the cursor and queue the results it causes
  function automatic void predict_screen_ops(input console_req_t r);
    screen_op_t ops [2];
    int n;
    bit done;
    logic [CP_W-1:0] code;
    n = 0;
    done = 1'b0;
    code = '0;
    ops[0] = '0;
    ops[1] = '0;
    if (r.kind == REQ_SETPOS) begin
      if (32'(r.col) < screen_cols()) caret_c = 32'(r.col);
      if (32'(r.row) < screen_rows()) caret_r = 32'(r.row);
    end else if (r.data < 8'h80) begin
      owed = 0;
      partial = '0;
      code = CP_W'(r.data);
      done = 1'b1;
    end else if ((r.data & LEAD2_MASK) == LEAD2_PAT) begin
      owed = 1;
      partial = CP_W'(r.data & LEAD2_BITS);
    end else if ((r.data & LEAD3_MASK) == LEAD3_PAT) begin
      owed = 2;
      partial = CP_W'(r.data & LEAD3_BITS);
    end else if ((r.data & LEAD4_MASK) == LEAD4_PAT) begin
      owed = 3;
      partial = CP_W'(r.data & LEAD4_BITS);
    end else if ((r.data & CONT_MASK) == CONT_PAT && owed != 0) begin
      partial = {partial[CP_W-7:0], r.data[5:0]};
      owed--;
      if (owed == 0) begin
        code = partial;
        partial = '0;
        done = 1'b1;
      end
    end else begin
      // stray continuation or 0xF8..0xFF
      owed = 0;
      partial = '0;
      code = CP_INVALID;
      done = 1'b1;
    end

    if (done) begin
      if (code == CP_NEWLINE) begin
        if (wrap_line()) begin
          ops[0].action = ACT_SCROLL;
          n = 1;
        end
      end else if (code == CP_RETURN) begin
        caret_c = 0;
      end else if (code == CP_TAB) begin
        caret_c = (caret_c + TAB_STEP) & ~(TAB_STEP - 1);
        if (caret_c >= screen_cols()) begin
          if (wrap_line()) begin
            ops[0].action = ACT_SCROLL;
            n = 1;
          end
        end
      end else if (code == CP_BACK) begin
        if (caret_c > 0) caret_c--;
      end else begin
        ops[0].action = ACT_DRAW;
        ops[0].cp = code;
        ops[0].at_col = PORT_COL_W'(caret_c);
        ops[0].at_row = PORT_ROW_W'(caret_r);
        n = 1;
        caret_c++;
        if (caret_c >= screen_cols()) begin
          if (wrap_line()) begin
            ops[1].action = ACT_SCROLL;
            n = 2;
          end
        end
      end
    end

    if (n == 0) begin
      ops[0].action = ACT_STATUS;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      ops[k].pos_col = PORT_COL_W'(caret_c);
      ops[k].pos_row = PORT_ROW_W'(caret_r);
      ops[k].last = (k == n - 1);
      screen_ops_due.push_back(ops[k]);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every result transaction with the oldest expected one
  always @(posedge clk_i) begin : result_check
    screen_op_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (screen_ops_due.size() == 0) begin
        $display("%0t ns: result with none expected, expected nothing actual action %0d cp %0h",
                 $time, action_o, code_point_o);
        mismatches++;
      end else begin
        want = screen_ops_due.pop_front();
        check_field("action", 32'(want.action), 32'(action_o));
        check_field("code_point", 32'(want.cp), 32'(code_point_o));
        check_field("at_col", 32'(want.at_col), 32'(at_col_o));
        check_field("at_row", 32'(want.at_row), 32'(at_row_o));
        check_field("pos_col", 32'(want.pos_col), 32'(pos_col_o));
        check_field("pos_row", 32'(want.pos_row), 32'(pos_row_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // Watchdog: ends the run after too long without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result receiver: random stall bursts, plus a long hold-off on request
  initial begin : result_receiver
    int unsigned stall;
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_len) @(negedge clk_i);
        hold_len = 0;
        out_ready_i <= 1'b1;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 16);
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one input transaction and wait until it is taken
  task automatic send_item(input console_req_t r);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= r.kind;
    byte_in_i <= r.data;
    new_col_i <= r.col;
    new_row_i <= r.row;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_screen_ops(r);
    items_sent++;
  endtask

  // Unused fields carry random values so that they are shown to be ignored
  task automatic send_byte(input logic [7:0] b);
    console_req_t r;
    r.kind = REQ_BYTE;
    r.data = b;
    r.col = PORT_COL_W'($urandom_range(0, 511));
    r.row = PORT_ROW_W'($urandom_range(0, 255));
    send_item(r);
  endtask

  task automatic send_setpos(input int unsigned c, input int unsigned rw);
    console_req_t r;
    r.kind = REQ_SETPOS;
    r.data = 8'($urandom_range(0, 255));
    r.col = PORT_COL_W'(c);
    r.row = PORT_ROW_W'(rw);
    send_item(r);
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (screen_ops_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DAT_W-1:0] value);
    settle_block();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_IDX_COLS) cols_reg = value;
    else rows_reg = value[CFG_ROW_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random piece of text: mostly well-formed characters, some noise
  task automatic send_random_text();
    int unsigned pick, len, conts;
    logic [7:0] lead;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      if ($urandom_range(0, 1) != 0)
        send_setpos($urandom_range(0, screen_cols() - 1), $urandom_range(0, screen_rows() - 1));
      else
        send_setpos($urandom_range(0, 511), $urandom_range(0, 255));
    end else if (pick < 22) begin
      case ($urandom_range(0, 3))
        0: send_byte(CP_NEWLINE[7:0]);
        1: send_byte(CP_RETURN[7:0]);
        2: send_byte(CP_TAB[7:0]);
        default: send_byte(CP_BACK[7:0]);
      endcase
    end else if (pick < 42) begin
      send_byte(8'($urandom_range(0, 127)));
    end else if (pick < 90) begin
      // lead byte plus continuations; a few sequences are cut short
      len = $urandom_range(2, 4);
      case (len)
        2: lead = LEAD2_PAT | 8'($urandom_range(0, 31));
        3: lead = LEAD3_PAT | 8'($urandom_range(0, 15));
        default: lead = LEAD4_PAT | 8'($urandom_range(0, 7));
      endcase
      conts = (pick >= 84) ? $urandom_range(0, len - 2) : len - 1;
      send_byte(lead);
      repeat (conts) send_byte(CONT_PAT | 8'($urandom_range(0, 63)));
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Plain ASCII, controls and set-cursor at the reset screen size
  task automatic test_control_codes();
    send_byte(8'h41);
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(CP_BACK[7:0]);
    send_byte(CP_RETURN[7:0]);
    send_byte(CP_TAB[7:0]);
    send_byte(CP_NEWLINE[7:0]);
    send_setpos(80, 25);
    send_setpos(79, 200);
    send_setpos(300, 24);
    send_byte(8'h42);
  endtask

  // Multi-byte sequences, restarts and invalid bytes
  task automatic test_utf8_decoding();
    send_byte(8'hC3);
    send_byte(8'hA9);
    send_byte(8'hE2);
    send_byte(8'h82);
    send_byte(8'hAC);
    // largest value that four bytes can carry
    send_byte(8'hF7);
    send_byte(8'hBF);
    send_byte(8'hBF);
    send_byte(8'hBF);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'hF8);
    // lead byte in the middle of a sequence restarts it
    send_byte(8'hC3);
    send_byte(8'hE2);
    send_byte(8'h82);
    send_byte(8'hAC);
    // ASCII abandons a partial sequence
    send_byte(8'hE2);
    send_byte(8'h41);
    // overlong newline still moves the cursor
    send_byte(8'hC0);
    send_byte(8'h8A);
  endtask

  // Smallest, zero, oversized and largest screens; cursor left outside a shrunk screen
  task automatic test_screen_edges();
    write_reg(CFG_IDX_COLS, 10'd1);
    write_reg(CFG_IDX_ROWS, 10'd1);
    send_byte(8'h78);
    send_byte(CP_NEWLINE[7:0]);
    send_byte(CP_TAB[7:0]);
    send_setpos(5, 5);
    write_reg(CFG_IDX_COLS, 10'd0);
    write_reg(CFG_IDX_ROWS, 10'd0);
    send_byte(8'h79);
    write_reg(CFG_IDX_COLS, 10'h3FF);
    write_reg(CFG_IDX_ROWS, 10'h3FF);
    send_setpos(511, 255);
    send_byte(8'h5A);
    send_setpos(508, 0);
    send_byte(CP_TAB[7:0]);
    send_setpos(0, 0);
    send_byte(CP_BACK[7:0]);
    write_reg(CFG_IDX_COLS, 10'd80);
    write_reg(CFG_IDX_ROWS, 10'd25);
    send_setpos(70, 20);
    write_reg(CFG_IDX_COLS, 10'd10);
    write_reg(CFG_IDX_ROWS, 10'd5);
    send_byte(8'h71);
    send_byte(8'h72);
    write_reg(CFG_IDX_COLS, 10'd512);
    write_reg(CFG_IDX_ROWS, 10'd256);
    send_setpos(511, 255);
    send_byte(8'h2A);
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    int unsigned stop_at;
    write_reg(CFG_IDX_COLS, 10'd8);
    write_reg(CFG_IDX_ROWS, 10'd4);
    idle_on = 1'b0;
    stall_on = 1'b0;
    hold_len = HOLD_CYCLES;
    stop_at = items_sent + 40;
    while (items_sent < stop_at) send_random_text();
    settle_block();
  endtask

  // Random text over several screen sizes; the last phase runs at full rate
  task automatic test_random_text();
    int unsigned stop_at;
    logic [CFG_DAT_W-1:0] cols_pick, rows_pick;
    for (int phase = 0; phase < 6; phase++) begin
      idle_on = (phase < 5) && (phase % 3 != 2);
      stall_on = (phase < 5) && (phase % 2 == 0 || phase == 3);
      case ($urandom_range(0, 5))
        0: cols_pick = 10'd1;
        1: cols_pick = 10'd512;
        2: cols_pick = CFG_DAT_W'($urandom_range(513, 1023));
        3: cols_pick = 10'd0;
        default: cols_pick = CFG_DAT_W'($urandom_range(2, 100));
      endcase
      case ($urandom_range(0, 5))
        0: rows_pick = 10'd1;
        1: rows_pick = 10'd256;
        2: rows_pick = CFG_DAT_W'($urandom_range(257, 1023));
        3: rows_pick = 10'd0;
        default: rows_pick = CFG_DAT_W'($urandom_range(2, 40));
      endcase
      write_reg(CFG_IDX_COLS, cols_pick);
      write_reg(CFG_IDX_ROWS, rows_pick);
      stop_at = items_sent + 110;
      while (items_sent < stop_at) send_random_text();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    idle_on = 1'b1;
    stall_on = 1'b1;
    test_control_codes();
    test_utf8_decoding();
    test_screen_edges();
    test_output_backpressure();
    test_random_text();
    settle_block();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/utc_pkg.sv
rtl/utc_front.sv
rtl/utc_queue.sv
rtl/utc_back.sv
rtl/utf8_text_console_cursor.sv
sim/tb_top.sv
